// ===== rtl/opip_pkg.sv =====
// ----------------------------------------------------------------------------
// opip_pkg
// Shared constants and types for the orthogonal point-in-polygon block.
// ----------------------------------------------------------------------------
package opip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 12;

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int STEP_W = $clog2(MAX_VERTICES + 2);
  localparam int VTX_W  = 2 * COORD_BITS;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    LOC_OUTSIDE  = 2'd0,
    LOC_INSIDE   = 2'd1,
    LOC_BOUNDARY = 2'd2
  } loc_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_TRIM,
    ST_WALK,
    ST_DRAIN
  } state_t;

endpackage

// ===== rtl/orthogonal_point_in_polygon_top.sv =====
// ----------------------------------------------------------------------------
// orthogonal_point_in_polygon_top
// Crossing-number point-in-polygon test over a polygon held in vertex RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a word is taken at a rising edge with start high and busy
//   low. in_action selects a vertex load or a point query.
//   Loads never raise busy; they write the next RAM entry.
//   A load with in_last_vertex high closes the polygon, so the next load
//   starts a new one. Loads past MAX_VERTICES are dropped, the count holds.
//   A query raises busy and walks the stored ring of edges through the
//   single read port of the vertex RAM: two head reads (first and last
//   vertex, to drop a repeated closing point), then n+2 streamed reads that
//   slide a prev/cur/next window, one edge evaluated per cycle.
//   A query over n effective vertices is paced by the RAM read port,
//   which delivers one vertex a cycle.
//   A query on an empty polygon goes straight to ST_DRAIN and answers outside.
//   Result channel: out_valid pulses for one cycle with out_location
//   (outside, inside or boundary). The receiver cannot stall; busy is low
//   again in the strobe cycle, so the next word may be taken at once.
//   Reset clears the vertex count and arms a new polygon; RAM contents
//   stay undefined and are never read beyond the count.
// ----------------------------------------------------------------------------
module orthogonal_point_in_polygon_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_action,
  input  logic [opip_pkg::COORD_BITS-1:0] in_x_coord,
  input  logic [opip_pkg::COORD_BITS-1:0] in_y_coord,
  input  logic                           in_last_vertex,
  output logic                           out_valid,
  output logic [1:0]                     out_location
);

  // Vertex RAM: {x, y}, one write port (loads), one registered read port.
  logic [opip_pkg::VTX_W-1:0] vtx_mem [opip_pkg::MAX_VERTICES];
  logic [opip_pkg::VTX_W-1:0] rd_q;
  logic [opip_pkg::IDX_W-1:0] rd_addr;
  logic [opip_pkg::IDX_W-1:0] wr_addr;
  logic                       wr_en;

  opip_pkg::state_t state_r, state_nxt;

  logic [opip_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                        new_poly_r, new_poly_nxt;
  logic [opip_pkg::CNT_W-1:0]  neff_r, neff_nxt;
  logic [opip_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [1:0]                  fill_r, fill_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic                        win_vld_r, win_vld_nxt;
  logic                        par_r, par_nxt;
  logic                        bnd_r, bnd_nxt;
  logic                        out_valid_r, out_valid_nxt;
  opip_pkg::loc_t              loc_r, loc_nxt;

  // Payload registers: query point, first vertex, sliding window.
  opip_pkg::coord_t qx_r, qy_r;
  logic [opip_pkg::VTX_W-1:0] first_r;
  opip_pkg::coord_t px_r, cx_r, cy_r, nx_r, ny_r;

  logic                       accept;
  logic [opip_pkg::CNT_W-1:0] load_base;
  logic [opip_pkg::CNT_W-1:0] neff_calc;
  logic [opip_pkg::STEP_W-1:0] step_m1;
  logic [opip_pkg::STEP_W-1:0] last_step;

  // Edge evaluation on the current window.
  logic between, vert, bnd_edge, cross_a, cross_b, cross_c;

  assign accept = start && !busy;
  assign busy   = (state_r != opip_pkg::ST_IDLE);

  assign load_base = new_poly_r ? '0 : count_r;
  assign wr_en     = accept && (in_action == opip_pkg::ACT_LOAD) &&
                     (load_base < opip_pkg::CNT_W'(opip_pkg::MAX_VERTICES));
  assign wr_addr   = load_base[opip_pkg::IDX_W-1:0];

  // Drop a repeated closing vertex (rd_q holds the last stored vertex here).
  assign neff_calc = ((count_r >= opip_pkg::CNT_W'(2)) && (rd_q == first_r)) ?
                     count_r - opip_pkg::CNT_W'(1) : count_r;

  assign step_m1   = step_r - opip_pkg::STEP_W'(1);
  assign last_step = opip_pkg::STEP_W'(neff_r) + opip_pkg::STEP_W'(1);

  // Read address: head reads, then ring n-1, 0, 1, ..., n-1, 0.
  always_comb begin
    case (state_r)
      opip_pkg::ST_HEAD: rd_addr = opip_pkg::IDX_W'(count_r - opip_pkg::CNT_W'(1));
      opip_pkg::ST_WALK: begin
        if (step_r == '0) begin
          rd_addr = opip_pkg::IDX_W'(neff_r - opip_pkg::CNT_W'(1));
        end else if (step_m1 == opip_pkg::STEP_W'(neff_r)) begin
          rd_addr = '0;
        end else begin
          rd_addr = step_m1[opip_pkg::IDX_W-1:0];
        end
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vtx_mem[wr_addr] <= {in_x_coord, in_y_coord};
    end
    rd_q <= vtx_mem[rd_addr];
  end

  // Edge from cur to next, prev x for the vertex rule.
  always_comb begin
    between  = ((cx_r < qx_r) && (qx_r < nx_r)) || ((cx_r > qx_r) && (qx_r > nx_r));
    vert     = (cx_r == qx_r) && (cy_r <= qy_r);
    bnd_edge = (between && (qy_r == ny_r)) ||
               (vert && (cy_r == qy_r)) ||
               (vert && (nx_r == qx_r) && (qy_r <= ny_r));
    cross_a  = between && (qy_r > ny_r);
    cross_b  = vert && (nx_r != qx_r) && (nx_r > qx_r);
    cross_c  = vert && (px_r > qx_r);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    new_poly_nxt  = new_poly_r;
    neff_nxt      = neff_r;
    step_nxt      = step_r;
    fill_nxt      = fill_r;
    rd_vld_nxt    = (state_r == opip_pkg::ST_WALK);
    win_vld_nxt   = rd_vld_r && (fill_r >= 2'd2);
    par_nxt       = par_r;
    bnd_nxt       = bnd_r;
    out_valid_nxt = 1'b0;
    loc_nxt       = loc_r;

    // Advance the window fill count on each returned ring read, saturating at 3.
    if (rd_vld_r && (fill_r != 2'd3)) begin
      fill_nxt = fill_r + 2'd1;
    end
    if (win_vld_r) begin
      par_nxt = par_r ^ cross_a ^ cross_b ^ cross_c;
      bnd_nxt = bnd_r | bnd_edge;
    end

    case (state_r)
      opip_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_action == opip_pkg::ACT_LOAD) begin
            count_nxt    = wr_en ? load_base + opip_pkg::CNT_W'(1) : load_base;
            new_poly_nxt = in_last_vertex;
          end else begin
            par_nxt   = 1'b0;
            bnd_nxt   = 1'b0;
            state_nxt = (count_r == '0) ? opip_pkg::ST_DRAIN : opip_pkg::ST_HEAD;
          end
        end
      end
      opip_pkg::ST_HEAD: state_nxt = opip_pkg::ST_TRIM;
      opip_pkg::ST_TRIM: begin
        neff_nxt  = neff_calc;
        step_nxt  = '0;
        fill_nxt  = 2'd0;
        state_nxt = opip_pkg::ST_WALK;
      end
      opip_pkg::ST_WALK: begin
        step_nxt = step_r + opip_pkg::STEP_W'(1);
        if (step_r == last_step) begin
          state_nxt = opip_pkg::ST_DRAIN;
        end
      end
      opip_pkg::ST_DRAIN: begin
        // Hold until the last edge has been folded into the flags.
        if (!rd_vld_r && !win_vld_r) begin
          out_valid_nxt = 1'b1;
          loc_nxt       = bnd_r ? opip_pkg::LOC_BOUNDARY :
                          (par_r ? opip_pkg::LOC_INSIDE : opip_pkg::LOC_OUTSIDE);
          state_nxt     = opip_pkg::ST_IDLE;
        end
      end
      default: state_nxt = opip_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= opip_pkg::ST_IDLE;
      count_r     <= '0;
      new_poly_r  <= 1'b1;
      fill_r      <= 2'd0;
      rd_vld_r    <= 1'b0;
      win_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      new_poly_r  <= new_poly_nxt;
      fill_r      <= fill_nxt;
      rd_vld_r    <= rd_vld_nxt;
      win_vld_r   <= win_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neff_r <= neff_nxt;
    step_r <= step_nxt;
    par_r  <= par_nxt;
    bnd_r  <= bnd_nxt;
    loc_r  <= loc_nxt;
    if (accept && (in_action == opip_pkg::ACT_QUERY)) begin
      qx_r <= in_x_coord;
      qy_r <= in_y_coord;
    end
    if (state_r == opip_pkg::ST_HEAD) begin
      first_r <= rd_q;
    end
    // Slide the window: prev <- cur <- next <- RAM.
    if (rd_vld_r) begin
      px_r <= cx_r;
      cx_r <= nx_r;
      cy_r <= ny_r;
      nx_r <= rd_q[opip_pkg::VTX_W-1:opip_pkg::COORD_BITS];
      ny_r <= rd_q[opip_pkg::COORD_BITS-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_location = loc_r;

endmodule

// ===== rtl/opip_checker.sv =====
// ----------------------------------------------------------------------------
// opip_checker
// Port-level checks for the point-in-polygon block, bound to the top level.
// ----------------------------------------------------------------------------
module opip_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_action,
  input logic       out_valid,
  input logic [1:0] out_location
);

  a_loc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_location == opip_pkg::LOC_OUTSIDE ||
                   out_location == opip_pkg::LOC_INSIDE ||
                   out_location == opip_pkg::LOC_BOUNDARY))
    else $error("result word carries an undefined location code");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == opip_pkg::ACT_QUERY) |=> busy)
    else $error("query word taken without raising busy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == opip_pkg::ACT_LOAD) |=> !busy && !out_valid)
    else $error("load word raised busy or produced a result");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a query in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind orthogonal_point_in_polygon_top opip_checker u_opip_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_action    (in_action),
  .out_valid    (out_valid),
  .out_location (out_location)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for orthogonal_point_in_polygon_top. Vertex loads and
// point queries go in as command words with random gaps; a local crossing
// number predictor keeps its own copy of the vertex ring and queues one
// expected location per accepted query, which the result monitor checks.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_WORDS = 1560;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = opip_pkg::MAX_VERTICES + 40;
  localparam int MAX_REPORTS  = 10;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             start          = 1'b0;
  logic             in_action      = 1'b0;
  opip_pkg::coord_t in_x_coord     = '0;
  opip_pkg::coord_t in_y_coord     = '0;
  logic             in_last_vertex = 1'b0;
  logic       busy;
  logic       out_valid;
  logic [1:0] out_location;

  // Predictor copy of the block's vertex RAM and polygon bookkeeping.
  opip_pkg::coord_t ring_x [opip_pkg::MAX_VERTICES];
  opip_pkg::coord_t ring_y [opip_pkg::MAX_VERTICES];
  int     ring_count = 0;
  bit     ring_new   = 1'b1;

  opip_pkg::loc_t expected_loc [$];
  int   mismatches  = 0;
  int   words_sent  = 0;
  int   gap_max     = 6;
  int   cycle_count = 0;

  orthogonal_point_in_polygon_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_location   (out_location)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Crossing number over the predictor's ring, ray toward smaller y.
  function automatic opip_pkg::loc_t classify_point(opip_pkg::coord_t qx,
                                                    opip_pkg::coord_t qy);
    int n, crossings, i, nx, pv;
    int px, py, ax, ay, bx, by, cx;
    px = qx;
    py = qy;
    n = ring_count;
    crossings = 0;
    // Drop a closing point that repeats the first vertex.
    if (n >= 2 && ring_x[0] == ring_x[n-1] && ring_y[0] == ring_y[n-1]) n--;
    if (n == 0) return opip_pkg::LOC_OUTSIDE;
    for (i = 0; i < n; i++) begin
      nx = (i + 1 == n) ? 0 : i + 1;
      pv = (i == 0) ? n - 1 : i - 1;
      ax = ring_x[i];
      ay = ring_y[i];
      bx = ring_x[nx];
      by = ring_y[nx];
      cx = ring_x[pv];
      // Edge spanning the query x: its height is the end vertex's y.
      if ((ax < px && px < bx) || (ax > px && px > bx)) begin
        if (py == by) return opip_pkg::LOC_BOUNDARY;
        if (py > by) crossings++;
      end
      // Vertex straight below (or at) the query point.
      if (ax == px && ay <= py) begin
        if (ay == py) return opip_pkg::LOC_BOUNDARY;
        if (bx == px) begin
          if ((ay <= py && py <= by) || (ay >= py && py >= by))
            return opip_pkg::LOC_BOUNDARY;
        end else if (bx > px) begin
          crossings++;
        end
        if (cx > px) crossings++;
      end
    end
    return crossings[0] ? opip_pkg::LOC_INSIDE : opip_pkg::LOC_OUTSIDE;
  endfunction

  // Send one command word: idle for a random gap, raise start, hold until
  // the block takes the word, then update the predictor. Leave start high
  // so a zero gap on the next word needs no second assignment this step.
  task automatic send_word(opip_pkg::action_t act, opip_pkg::coord_t x,
                           opip_pkg::coord_t y, logic last);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_action      <= act;
    in_x_coord     <= x;
    in_y_coord     <= y;
    in_last_vertex <= last;
    // busy read right after the edge is the value the block sampled.
    do @(posedge clk); while (busy);
    words_sent++;
    if (act == opip_pkg::ACT_LOAD) begin
      if (ring_new) ring_count = 0;
      if (ring_count < opip_pkg::MAX_VERTICES) begin
        ring_x[ring_count] = x;
        ring_y[ring_count] = y;
        ring_count++;
      end
      ring_new = last;
    end else begin
      expected_loc = {expected_loc, classify_point(x, y)};
    end
  endtask

  // Query near a coordinate grid: on grid points, one off them, inside the
  // grid window, or anywhere. The last flag is random since queries ignore it.
  task automatic send_probe(int bx, int by, int step);
    int qx, qy;
    case ($urandom_range(0, 3))
      0: begin
        qx = bx + step * $urandom_range(0, 7);
        qy = by + step * $urandom_range(0, 7);
      end
      1: begin
        qx = bx + step * $urandom_range(0, 7) + $urandom_range(0, 2) - 1;
        qy = by + step * $urandom_range(0, 7) + $urandom_range(0, 2) - 1;
      end
      2: begin
        qx = bx + $urandom_range(0, step * 7);
        qy = by + $urandom_range(0, step * 7);
      end
      default: begin
        qx = $urandom_range(0, 4095);
        qy = $urandom_range(0, 4095);
      end
    endcase
    send_word(opip_pkg::ACT_QUERY, opip_pkg::coord_t'(qx), opip_pkg::coord_t'(qy),
              1'($urandom_range(0, 1)));
  endtask

  // Load an orthogonal ring of 2*m vertices from m x values and m y values,
  // alternating horizontal and vertical edges. Optionally repeat the first
  // vertex as closing point, and drop queries in while loading.
  task automatic load_ortho_ring(int m, int bx, int by, int step, bit repeat_first,
                                 bit probe_midway);
    int xs [32];
    int ys [32];
    int j;
    for (j = 0; j < m; j++) begin
      xs[j] = bx + step * $urandom_range(0, 7);
      ys[j] = by + step * $urandom_range(0, 7);
    end
    for (j = 0; j < m; j++) begin
      send_word(opip_pkg::ACT_LOAD, opip_pkg::coord_t'(xs[j]), opip_pkg::coord_t'(ys[j]),
                1'b0);
      if (probe_midway && $urandom_range(0, 3) == 0) send_probe(bx, by, step);
      send_word(opip_pkg::ACT_LOAD, opip_pkg::coord_t'(xs[(j+1) % m]),
                opip_pkg::coord_t'(ys[j]), (j == m - 1) && !repeat_first);
    end
    if (repeat_first)
      send_word(opip_pkg::ACT_LOAD, opip_pkg::coord_t'(xs[0]), opip_pkg::coord_t'(ys[0]),
                1'b1);
  endtask

  // A query before any vertex is loaded answers outside.
  task automatic test_empty_polygon();
    send_word(opip_pkg::ACT_QUERY, 12'd2048, 12'd2048, 1'b0);
  endtask

  // Full-range square: corner hits and the center.
  task automatic test_coord_extremes();
    send_word(opip_pkg::ACT_LOAD, 12'd0,    12'd0,    1'b0);
    send_word(opip_pkg::ACT_LOAD, 12'd4095, 12'd0,    1'b0);
    send_word(opip_pkg::ACT_LOAD, 12'd4095, 12'd4095, 1'b0);
    send_word(opip_pkg::ACT_LOAD, 12'd0,    12'd4095, 1'b1);
    send_word(opip_pkg::ACT_QUERY, 12'd0,    12'd0,    1'b1);
    send_word(opip_pkg::ACT_QUERY, 12'd4095, 12'd4095, 1'b0);
    send_word(opip_pkg::ACT_QUERY, 12'd2048, 12'd2048, 1'b0);
  endtask

  // Small square closed by a repeat of its first vertex; probe inside,
  // outside, on edges and in the column over a vertex.
  task automatic test_vertex_rules();
    send_word(opip_pkg::ACT_LOAD, 12'd100, 12'd100, 1'b0);
    send_word(opip_pkg::ACT_LOAD, 12'd200, 12'd100, 1'b0);
    send_word(opip_pkg::ACT_LOAD, 12'd200, 12'd200, 1'b0);
    send_word(opip_pkg::ACT_LOAD, 12'd100, 12'd200, 1'b0);
    send_word(opip_pkg::ACT_LOAD, 12'd100, 12'd100, 1'b1);
    send_word(opip_pkg::ACT_QUERY, 12'd150, 12'd150, 1'b0);
    send_word(opip_pkg::ACT_QUERY, 12'd150, 12'd50,  1'b0);
    send_word(opip_pkg::ACT_QUERY, 12'd100, 12'd150, 1'b0);
    send_word(opip_pkg::ACT_QUERY, 12'd150, 12'd100, 1'b0);
    send_word(opip_pkg::ACT_QUERY, 12'd100, 12'd300, 1'b0);
  endtask

  // Query with a polygon still open, then append to it.
  task automatic test_open_polygon();
    send_word(opip_pkg::ACT_LOAD, 12'd10, 12'd10, 1'b0);
    send_word(opip_pkg::ACT_LOAD, 12'd30, 12'd10, 1'b0);
    send_word(opip_pkg::ACT_QUERY, 12'd20, 12'd20, 1'b0);
    send_word(opip_pkg::ACT_LOAD, 12'd30, 12'd30, 1'b0);
    send_word(opip_pkg::ACT_QUERY, 12'd20, 12'd20, 1'b0);
  endtask

  // Load past the vertex limit; the last flag lands on a dropped load.
  task automatic test_vertex_overflow();
    int rep, j, extra, step, bx, by;
    for (rep = 0; rep < 3; rep++) begin
      step  = $urandom_range(1, 4);
      bx    = $urandom_range(0, 4095 - 7 * step);
      by    = $urandom_range(0, 4095 - 7 * step);
      extra = $urandom_range(1, 4);
      for (j = 0; j < opip_pkg::MAX_VERTICES + extra; j++) begin
        send_word(opip_pkg::ACT_LOAD, opip_pkg::coord_t'(bx + step * $urandom_range(0, 7)),
                  opip_pkg::coord_t'(by + step * $urandom_range(0, 7)),
                  j == opip_pkg::MAX_VERTICES + extra - 1);
      end
      repeat (6) send_probe(bx, by, step);
    end
  endtask

  // Mostly well-formed orthogonal rings with random content and sizes;
  // the rest is noise: free-form rings, tiny rings and unterminated loads.
  task automatic test_random_polygons();
    int first, kind, m, step, bx, by, j, nq;
    first = words_sent;
    while (words_sent - first < RANDOM_WORDS) begin
      // Alternate bursts without idle cycles with gappy stretches.
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      step = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 585);
      bx   = $urandom_range(0, 4095 - 7 * step);
      by   = $urandom_range(0, 4095 - 7 * step);
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        m = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 32) : $urandom_range(2, 6);
        load_ortho_ring(m, bx, by, step, $urandom_range(0, 4) == 0,
                        $urandom_range(0, 3) == 0);
      end else if (kind < 18) begin
        m = $urandom_range(1, 8);
        for (j = 0; j < m; j++) begin
          send_word(opip_pkg::ACT_LOAD,
                    opip_pkg::coord_t'(bx + step * $urandom_range(0, 7)),
                    opip_pkg::coord_t'(by + step * $urandom_range(0, 7)), j == m - 1);
        end
      end else begin
        // Leave the polygon open so the next ring appends to it.
        m = $urandom_range(1, 3);
        for (j = 0; j < m; j++) begin
          send_word(opip_pkg::ACT_LOAD, opip_pkg::coord_t'($urandom_range(0, 4095)),
                    opip_pkg::coord_t'($urandom_range(0, 4095)), 1'b0);
        end
      end
      nq = $urandom_range(2, 10);
      for (j = 0; j < nq; j++) send_probe(bx, by, step);
    end
    gap_max = 6;
  endtask

  // Result monitor: outputs read right after the edge are the values that
  // the edge accepted, so there is no race with the block's own updates.
  always @(posedge clk) begin
    opip_pkg::loc_t want;
    if (rst_n && out_valid) begin
      if (expected_loc.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: location %0d", out_location);
      end else begin
        want = expected_loc.pop_front();
        if (out_location !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("location mismatch: expected %0d actual %0d", want, out_location);
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release it on an edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_polygon();
    test_coord_extremes();
    test_vertex_rules();
    test_open_polygon();
    test_vertex_overflow();
    test_random_polygons();
    start <= 1'b0;

    // Drain outstanding queries, then watch for stray strobes.
    while (expected_loc.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_loc.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
